// ===== design/eos_pkg.sv =====
// Shared types and codes for the elevator order scheduler.
// Holds command, direction and button codes and the controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps

package eos_pkg;

    typedef enum logic [2:0] {
        CMD_ADD         = 3'd0,
        CMD_CLEAR_FLOOR = 3'd1,
        CMD_CLEAR_ALL   = 3'd2,
        CMD_DIRECTION   = 3'd3,
        CMD_TARGET      = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // Button kinds of an order, also the bit position within a floor's row
    localparam logic [1:0] BTN_UP   = 2'd0;
    localparam logic [1:0] BTN_DOWN = 2'd1;
    localparam logic [1:0] BTN_CAB  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH,
        S_OUT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic scan;
        logic finish;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_cmd;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== design/eos_ctrl.sv =====
// Sequencing controller for the elevator order scheduler.
// Steps each request through execute, floor scan and finish for scanning commands, and output load.
// Depends on eos_pkg.
`timescale 1ns / 1ps

module eos_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  eos_pkg::dp_stat_t stat,
    output eos_pkg::dp_cmd_t  cmd
);

    eos_pkg::ctrl_state_t state_reg;
    eos_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eos_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            eos_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = eos_pkg::S_EXEC;
                end
            end
            eos_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.scan_cmd)
                begin
                    state_next = eos_pkg::S_SCAN;
                end
                else
                begin
                    state_next = eos_pkg::S_OUT;
                end
            end
            eos_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = eos_pkg::S_FINISH;
                end
            end
            eos_pkg::S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = eos_pkg::S_OUT;
            end
            eos_pkg::S_OUT:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = eos_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = eos_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/eos_dpath.sv =====
// Datapath for the elevator order scheduler: order table, direction, target,
// one-floor-per-cycle scan unit and the output register.
// Depends on eos_pkg.
`timescale 1ns / 1ps

module eos_dpath #(
    parameter int FLOORS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  eos_pkg::dp_cmd_t  cmd,
    output eos_pkg::dp_stat_t stat,
    input  logic [2:0]        in_command,
    input  logic [1:0]        in_button,
    input  logic [1:0]        in_floor,
    input  logic [1:0]        in_current_floor,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [23:0]       out_data
);

    localparam int IW = $clog2(FLOORS);
    localparam int PF = (FLOORS < 4) ? FLOORS : 4;
    localparam logic [IW-1:0] LAST = IW'(FLOORS - 1);

    logic [2:0]          order_reg [FLOORS];
    logic [2:0]          order_next [FLOORS];
    logic [2:0]          cmd_reg, cmd_next;
    logic [1:0]          btn_reg, btn_next;
    logic [1:0]          flr_reg, flr_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       acc_a_reg, acc_a_next;
    logic [IW-1:0]       acc_b_reg, acc_b_next;
    logic                hit_a_reg, hit_a_next;
    logic                hit_b_reg, hit_b_next;
    eos_pkg::dir_t       dir_reg, dir_next;
    logic [1:0]          tgt_reg, tgt_next;
    logic                empty_reg, empty_next;
    logic                out_valid_reg, out_valid_next;
    logic [23:0]         out_data_reg, out_data_next;

    logic [2:0]          row;
    logic                nz;
    logic                match_a, first_a, match_b, first_b;
    logic [IW-1:0]       flr_idx;
    logic                flr_ok;
    logic [IW-1:0]       found;
    logic [11:0]         pending;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < FLOORS; f++)
            begin
                order_reg[f] <= '0;
            end
            dir_reg       <= eos_pkg::DIR_STOP;
            tgt_reg       <= '0;
            empty_reg     <= 1'b1;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            order_reg     <= order_next;
            dir_reg       <= dir_next;
            tgt_reg       <= tgt_next;
            empty_reg     <= empty_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        btn_reg      <= btn_next;
        flr_reg      <= flr_next;
        cur_reg      <= cur_next;
        acc_a_reg    <= acc_a_next;
        acc_b_reg    <= acc_b_next;
        hit_a_reg    <= hit_a_next;
        hit_b_reg    <= hit_b_next;
        out_data_reg <= out_data_next;
    end

    assign row     = order_reg[idx_reg];
    assign nz      = |row;
    assign flr_idx = IW'(flr_reg);
    assign flr_ok  = (32'(flr_reg) < FLOORS);

    // Match rules of the scan, per command and direction
    always_comb
    begin
        match_a = 1'b0;
        first_a = 1'b0;
        match_b = 1'b0;
        first_b = 1'b0;
        case (cmd_reg)
            eos_pkg::CMD_CLEAR_FLOOR:
            begin
                match_a = nz;
            end
            eos_pkg::CMD_DIRECTION:
            begin
                case (dir_reg)
                    eos_pkg::DIR_STOP: match_a = nz;
                    eos_pkg::DIR_UP:   match_a = nz && (idx_reg >= cur_reg);
                    eos_pkg::DIR_DOWN:
                    begin
                        match_a = nz && (idx_reg <= cur_reg);
                        first_a = 1'b1;
                    end
                    default: match_a = 1'b0;
                endcase
            end
            eos_pkg::CMD_TARGET:
            begin
                case (dir_reg)
                    eos_pkg::DIR_UP:
                    begin
                        match_a = (row[eos_pkg::BTN_CAB] || row[eos_pkg::BTN_UP])
                               && (idx_reg > cur_reg);
                        first_a = 1'b1;
                        match_b = row[eos_pkg::BTN_DOWN] && (idx_reg > cur_reg);
                    end
                    eos_pkg::DIR_DOWN:
                    begin
                        match_a = (row[eos_pkg::BTN_CAB] || row[eos_pkg::BTN_DOWN])
                               && (idx_reg < cur_reg);
                        match_b = row[eos_pkg::BTN_UP] && (idx_reg < cur_reg);
                        first_b = 1'b1;
                    end
                    default: match_a = 1'b0;
                endcase
            end
            default: match_a = 1'b0;
        endcase
    end

    // Default of the direction search when nothing matched
    always_comb
    begin
        case (dir_reg)
            eos_pkg::DIR_UP:   found = hit_a_reg ? acc_a_reg : LAST;
            eos_pkg::DIR_DOWN: found = hit_a_reg ? acc_a_reg : '0;
            default:           found = hit_a_reg ? acc_a_reg : cur_reg;
        endcase
    end

    always_comb
    begin
        pending = '0;
        for (int f = 0; f < PF; f++)
        begin
            pending[3*f +: 3] = order_reg[f];
        end
    end

    always_comb
    begin
        order_next     = order_reg;
        cmd_next       = cmd_reg;
        btn_next       = btn_reg;
        flr_next       = flr_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        acc_a_next     = acc_a_reg;
        acc_b_next     = acc_b_reg;
        hit_a_next     = hit_a_reg;
        hit_b_next     = hit_b_reg;
        dir_next       = dir_reg;
        tgt_next       = tgt_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cmd.load_in)
        begin
            cmd_next = in_command;
            btn_next = in_button;
            flr_next = in_floor;
            // clamp the car position into the table
            if (32'(in_current_floor) >= FLOORS)
            begin
                cur_next = LAST;
            end
            else
            begin
                cur_next = IW'(in_current_floor);
            end
        end

        if (cmd.exec)
        begin
            idx_next   = '0;
            hit_a_next = 1'b0;
            hit_b_next = 1'b0;
            case (cmd_reg)
                eos_pkg::CMD_ADD:
                begin
                    if (btn_reg <= eos_pkg::BTN_CAB && flr_ok)
                    begin
                        order_next[flr_idx] = order_reg[flr_idx] | (3'b001 << btn_reg);
                        empty_next          = 1'b0;
                    end
                end
                eos_pkg::CMD_CLEAR_FLOOR:
                begin
                    if (flr_ok)
                    begin
                        order_next[flr_idx] = '0;
                    end
                end
                eos_pkg::CMD_CLEAR_ALL:
                begin
                    for (int f = 0; f < FLOORS; f++)
                    begin
                        order_next[f] = '0;
                    end
                    empty_next = 1'b1;
                end
                default: empty_next = empty_reg;
            endcase
        end

        if (cmd.scan)
        begin
            if (match_a && (!first_a || !hit_a_reg))
            begin
                acc_a_next = idx_reg;
                hit_a_next = 1'b1;
            end
            if (match_b && (!first_b || !hit_b_reg))
            begin
                acc_b_next = idx_reg;
                hit_b_next = 1'b1;
            end
            if (idx_reg != LAST)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (cmd.finish)
        begin
            case (cmd_reg)
                eos_pkg::CMD_CLEAR_FLOOR:
                begin
                    empty_next = !hit_a_reg;
                end
                eos_pkg::CMD_DIRECTION:
                begin
                    case (dir_reg)
                        eos_pkg::DIR_STOP:
                        begin
                            if (found > cur_reg)
                            begin
                                dir_next = eos_pkg::DIR_UP;
                            end
                            else if (found < cur_reg)
                            begin
                                dir_next = eos_pkg::DIR_DOWN;
                            end
                        end
                        eos_pkg::DIR_UP, eos_pkg::DIR_DOWN:
                        begin
                            if (found == cur_reg)
                            begin
                                dir_next = eos_pkg::DIR_STOP;
                            end
                        end
                        default: dir_next = dir_reg;
                    endcase
                end
                eos_pkg::CMD_TARGET:
                begin
                    if (hit_a_reg)
                    begin
                        tgt_next = 2'(acc_a_reg);
                    end
                    else if (hit_b_reg)
                    begin
                        tgt_next = 2'(acc_b_reg);
                    end
                end
                default: dir_next = dir_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {7'b0, pending, tgt_reg, dir_reg, empty_reg};
        end
    end

    assign stat.scan_cmd  = (cmd_reg == eos_pkg::CMD_CLEAR_FLOOR)
                         || (cmd_reg == eos_pkg::CMD_DIRECTION)
                         || (cmd_reg == eos_pkg::CMD_TARGET);
    assign stat.scan_last = (idx_reg == LAST);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/elevator_order_scheduler.sv =====
// Elevator order scheduler, top level.
// Add, clear-all and unknown commands pass from the taken request through the execute and
// output-load states; clear-floor, direction and target updates also pass through the
// scan unit, which visits one floor of the order table per cycle, and a finish state.
// The block takes a new request only once the previous result is in the output register.
// Reset (rst_n low, asynchronous): orders cleared, direction stop, target 0, empty set.
`timescale 1ns / 1ps

module elevator_order_scheduler #(
    parameter int FLOORS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [1:0] button, [3:2] floor, [5:4] current_floor, [7:6] zero
    input  logic [2:0]  s_tuser,  // [2:0] command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // [0] queue_empty, [2:1] direction, [4:3] target_floor,
                                  // [16:5] pending_orders, [23:17] zero
);

    eos_pkg::dp_cmd_t  dp_cmd;
    eos_pkg::dp_stat_t dp_stat;

    // Controller: take one request at a time, sequence the scan, hold for the output
    eos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // Datapath: order table, direction and target state, scan unit and result register.
    // The result register lets the next request in while a result still waits.
    eos_dpath #(
        .FLOORS (FLOORS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (dp_cmd),
        .stat             (dp_stat),
        .in_command       (s_tuser),
        .in_button        (s_tdata[1:0]),
        .in_floor         (s_tdata[3:2]),
        .in_current_floor (s_tdata[5:4]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_data         (m_tdata)
    );

endmodule

// ===== dv/tb_elevator_order_scheduler.sv =====
// Testbench for elevator_order_scheduler: drives order-table commands and checks each status.
// A scoreboard class predicts the status word; relies on eos_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_elevator_order_scheduler;

    localparam int FLOORS = 4;

    // Button code outside the valid kinds and the reserved command codes
    localparam logic [1:0] BUTTON_INVALID   = 2'd3;
    localparam logic [2:0] CMD_RSVD_FIRST   = 3'd5;
    localparam logic [2:0] CMD_RSVD_MID     = 3'd6;
    localparam logic [2:0] CMD_RSVD_LAST    = 3'd7;

    typedef struct packed {
        logic          queue_empty;
        eos_pkg::dir_t direction;
        logic [1:0]    target_floor;
        logic [11:0]   pending_orders;
    } car_status_t;

    // Scoreboard: mirrors the order table and queues the status word for each request
    class order_scoreboard;
        logic [2:0]    orders [FLOORS];
        eos_pkg::dir_t dir;
        logic [1:0]    tgt;
        logic          queue_empty;
        car_status_t   status_q[$];
        int            errors;

        function new();
            foreach (orders[f])
                orders[f] = 3'b000;
            dir         = eos_pkg::DIR_STOP;
            tgt         = 2'd0;
            queue_empty = 1'b1;
            errors      = 0;
        endfunction

        function void note_request(logic [2:0] cmd, logic [1:0] btn, logic [1:0] flr,
                                   logic [1:0] cur_in);
            int          f;
            int          cur;
            int          found;
            car_status_t st;
            cur = int'(cur_in);
            if (cur >= FLOORS)
                cur = FLOORS - 1;
            case (cmd)
                eos_pkg::CMD_ADD:
                    if (btn <= eos_pkg::BTN_CAB && int'(flr) < FLOORS)
                    begin
                        orders[flr][btn] = 1'b1;
                        queue_empty      = 1'b0;
                    end
                eos_pkg::CMD_CLEAR_FLOOR:
                    if (int'(flr) < FLOORS)
                    begin
                        orders[flr] = 3'b000;
                        queue_empty = 1'b1;
                        for (f = 0; f < FLOORS; f++)
                            if (orders[f] != 3'b000)
                                queue_empty = 1'b0;
                    end
                eos_pkg::CMD_CLEAR_ALL:
                begin
                    for (f = 0; f < FLOORS; f++)
                        orders[f] = 3'b000;
                    queue_empty = 1'b1;
                end
                eos_pkg::CMD_DIRECTION:
                    if (dir == eos_pkg::DIR_STOP)
                    begin
                        found = cur;
                        for (f = 0; f < FLOORS; f++)
                            if (orders[f] != 3'b000)
                                found = f;
                        if (found > cur)
                            dir = eos_pkg::DIR_UP;
                        else if (found < cur)
                            dir = eos_pkg::DIR_DOWN;
                    end
                    else if (dir == eos_pkg::DIR_UP)
                    begin
                        found = FLOORS - 1;
                        for (f = cur; f < FLOORS; f++)
                            if (orders[f] != 3'b000)
                                found = f;
                        if (found == cur)
                            dir = eos_pkg::DIR_STOP;
                    end
                    else if (dir == eos_pkg::DIR_DOWN)
                    begin
                        found = 0;
                        for (f = cur; f >= 0; f--)
                            if (orders[f] != 3'b000)
                                found = f;
                        if (found == cur)
                            dir = eos_pkg::DIR_STOP;
                    end
                eos_pkg::CMD_TARGET:
                    if (dir == eos_pkg::DIR_UP)
                    begin
                        // farthest call-down ahead, overridden by the nearest up/cabin
                        for (f = cur + 1; f < FLOORS; f++)
                            if (orders[f][eos_pkg::BTN_DOWN])
                                tgt = f[1:0];
                        for (f = FLOORS - 1; f > cur; f--)
                            if (orders[f][eos_pkg::BTN_CAB] || orders[f][eos_pkg::BTN_UP])
                                tgt = f[1:0];
                    end
                    else if (dir == eos_pkg::DIR_DOWN)
                    begin
                        for (f = cur - 1; f >= 0; f--)
                            if (orders[f][eos_pkg::BTN_UP])
                                tgt = f[1:0];
                        for (f = 0; f < cur; f++)
                            if (orders[f][eos_pkg::BTN_CAB] || orders[f][eos_pkg::BTN_DOWN])
                                tgt = f[1:0];
                    end
                default: ;
            endcase
            st.queue_empty    = queue_empty;
            st.direction      = dir;
            st.target_floor   = tgt;
            st.pending_orders = '0;
            for (f = 0; f < FLOORS && f < 4; f++)
                st.pending_orders[3*f +: 3] = orders[f];
            status_q.push_back(st);
        endfunction

        function int outstanding();
            return status_q.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("mismatch %0d: %s got 0x%0h, expected 0x%0h", errors, what, got, want);
        endtask

        task check_result(logic [23:0] word);
            car_status_t want;
            if (status_q.size() == 0)
            begin
                report_mismatch("status with no request waiting", int'(word), 0);
                return;
            end
            want = status_q.pop_front();
            if (word[0] !== want.queue_empty)
                report_mismatch("queue_empty", int'(word[0]), int'(want.queue_empty));
            if (word[2:1] !== want.direction)
                report_mismatch("direction", int'(word[2:1]), int'(want.direction));
            if (word[4:3] !== want.target_floor)
                report_mismatch("target_floor", int'(word[4:3]), int'(want.target_floor));
            if (word[16:5] !== want.pending_orders)
                report_mismatch("pending_orders", int'(word[16:5]),
                                int'(want.pending_orders));
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [1:0] button, [3:2] floor, [5:4] current_floor
    logic [2:0]  s_tuser  = 3'd0;    // [2:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [0] empty, [2:1] dir, [4:3] target, [16:5] orders

    order_scoreboard sb;
    bit              calm;           // both sides run without gaps while set
    bit              long_hold_req;  // ask the result side for a long hold-off

    elevator_order_scheduler #(
        .FLOORS (FLOORS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one request after an optional idle gap; hold it until the block takes it.
    // Leave tvalid high afterwards so back-to-back requests need no extra assignment.
    task automatic do_request(logic [2:0] cmd, logic [1:0] btn, logic [1:0] flr,
                              logic [1:0] cur, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, cur, flr, btn};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(cmd, btn, flr, cur);
    endtask

    // Result side: check every accepted status, then decide tready for the next cycle.
    // A long hold-off is counted here so the request side keeps pushing meanwhile.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (long_hold_req)
            begin
                hold_left     = 300;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready   <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Request side: directed cases first, then a car that wanders after its own orders
    initial
    begin
        int         car;
        int         burst_left;
        int         r;
        logic [2:0] cmd;
        logic [1:0] btn;
        logic [1:0] flr;
        logic [1:0] cur;

        sb            = new();
        calm          = 1'b0;
        long_hold_req = 1'b0;
        car           = 0;
        burst_left    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: direction and target stay put
        do_request(eos_pkg::CMD_DIRECTION, eos_pkg::BTN_UP, 2'd0, 2'd0, pick_gap());
        do_request(eos_pkg::CMD_TARGET, eos_pkg::BTN_UP, 2'd0, 2'd0, pick_gap());
        // Orders at both end floors, cabin in between; invalid button is dropped
        do_request(eos_pkg::CMD_ADD, eos_pkg::BTN_UP, 2'd0, 2'd0, pick_gap());
        do_request(eos_pkg::CMD_ADD, eos_pkg::BTN_DOWN, 2'd3, 2'd0, pick_gap());
        do_request(eos_pkg::CMD_ADD, eos_pkg::BTN_CAB, 2'd2, 2'd0, pick_gap());
        do_request(eos_pkg::CMD_ADD, BUTTON_INVALID, 2'd1, 2'd3, pick_gap());
        // Reserved commands only report the state
        do_request(CMD_RSVD_FIRST, BUTTON_INVALID, 2'd3, 2'd3, pick_gap());
        do_request(CMD_RSVD_MID, eos_pkg::BTN_CAB, 2'd1, 2'd2, pick_gap());
        do_request(CMD_RSVD_LAST, eos_pkg::BTN_DOWN, 2'd2, 2'd1, pick_gap());
        // Up from the ground floor, nearest cabin order first, stop at the top
        do_request(eos_pkg::CMD_DIRECTION, eos_pkg::BTN_UP, 2'd0, 2'd0, pick_gap());
        do_request(eos_pkg::CMD_TARGET, eos_pkg::BTN_UP, 2'd0, 2'd0, pick_gap());
        do_request(eos_pkg::CMD_DIRECTION, eos_pkg::BTN_UP, 2'd0, 2'd2, pick_gap());
        do_request(eos_pkg::CMD_DIRECTION, eos_pkg::BTN_UP, 2'd0, 2'd3, pick_gap());
        // Clear the top floor, then head down and stop at the ground floor
        do_request(eos_pkg::CMD_CLEAR_FLOOR, eos_pkg::BTN_UP, 2'd3, 2'd3, pick_gap());
        do_request(eos_pkg::CMD_DIRECTION, eos_pkg::BTN_UP, 2'd0, 2'd3, pick_gap());
        do_request(eos_pkg::CMD_TARGET, eos_pkg::BTN_UP, 2'd0, 2'd3, pick_gap());
        do_request(eos_pkg::CMD_DIRECTION, eos_pkg::BTN_UP, 2'd0, 2'd0, pick_gap());
        // Opposite calls only: target falls back to the farthest call-down ahead
        do_request(eos_pkg::CMD_CLEAR_ALL, eos_pkg::BTN_UP, 2'd0, 2'd0, pick_gap());
        do_request(eos_pkg::CMD_ADD, eos_pkg::BTN_DOWN, 2'd3, 2'd1, pick_gap());
        do_request(eos_pkg::CMD_ADD, eos_pkg::BTN_DOWN, 2'd2, 2'd1, pick_gap());
        do_request(eos_pkg::CMD_DIRECTION, eos_pkg::BTN_UP, 2'd0, 2'd1, pick_gap());
        do_request(eos_pkg::CMD_TARGET, eos_pkg::BTN_UP, 2'd0, 2'd1, pick_gap());
        // Moving up with nothing left ahead: stop only at the top floor
        do_request(eos_pkg::CMD_CLEAR_ALL, eos_pkg::BTN_UP, 2'd0, 2'd1, pick_gap());
        do_request(eos_pkg::CMD_DIRECTION, eos_pkg::BTN_UP, 2'd0, 2'd2, pick_gap());
        do_request(eos_pkg::CMD_DIRECTION, eos_pkg::BTN_UP, 2'd0, 2'd3, pick_gap());

        for (int n = 0; n < 450; n++)
        begin
            // Stall the result side for long while requests keep coming
            if (n == 150)
            begin
                long_hold_req = 1'b1;
                burst_left    = 20;
            end
            // Pause until every status has come back
            if (n == 300)
            begin
                s_tvalid <= 1'b0;
                while (sb.outstanding() != 0)
                    @(posedge clk);
            end
            calm = (n >= 200 && n < 260);

            // Advance the car one floor along its direction now and then
            if ($urandom_range(0, 2) == 0)
            begin
                if (sb.dir == eos_pkg::DIR_UP && car < FLOORS - 1)
                    car++;
                else if (sb.dir == eos_pkg::DIR_DOWN && car > 0)
                    car--;
            end

            cur = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : 2'(car);
            btn = ($urandom_range(0, 19) == 0) ? BUTTON_INVALID
                : 2'($urandom_range(eos_pkg::BTN_UP, eos_pkg::BTN_CAB));
            flr = 2'($urandom_range(0, 3));
            r   = $urandom_range(0, 99);
            if (r < 30)
                cmd = eos_pkg::CMD_ADD;
            else if (r < 40)
            begin
                cmd = eos_pkg::CMD_CLEAR_FLOOR;
                if ($urandom_range(0, 3) != 0)
                    flr = 2'(car);   // serve the floor the car stands on
            end
            else if (r < 44)
                cmd = eos_pkg::CMD_CLEAR_ALL;
            else if (r < 70)
                cmd = eos_pkg::CMD_DIRECTION;
            else if (r < 94)
                cmd = eos_pkg::CMD_TARGET;
            else
                cmd = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));

            if (burst_left > 0)
            begin
                burst_left--;
                do_request(cmd, btn, flr, cur, 0);
            end
            else
                do_request(cmd, btn, flr, cur, pick_gap());
        end

        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        // Let any stray status surface before the verdict
        repeat (4 * FLOORS) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/eos_pkg.sv
design/eos_ctrl.sv
design/eos_dpath.sv
design/elevator_order_scheduler.sv
dv/tb_elevator_order_scheduler.sv
